// ===== rtl/rdrf_pkg.sv =====
package rdrf_pkg;

  // Frame layout
  localparam logic [7:0] LOAD_OVERHEAD = 8'd6;
  localparam logic [7:0] MAX_PAYLOAD   = 8'd249;
  localparam logic [7:0] MIN_PAYLOAD   = 8'd1;
  localparam logic [7:0] FRAME_NUMBER  = 8'h00;

  // Output byte positions within one frame entry
  localparam logic [3:0] STEP_FTYPE   = 4'd0;
  localparam logic [3:0] STEP_FNUM    = 4'd1;
  localparam logic [3:0] STEP_CMD     = 4'd2;
  localparam logic [3:0] STEP_LOADLEN = 4'd3;
  localparam logic [3:0] STEP_ADDR_HI = 4'd4;
  localparam logic [3:0] STEP_ADDR_LO = 4'd5;
  localparam logic [3:0] STEP_ACK     = 4'd6;
  localparam logic [3:0] STEP_HOP     = 4'd7;
  localparam logic [3:0] STEP_ROUTE   = 4'd8;
  localparam logic [3:0] STEP_PLEN    = 4'd9;
  localparam logic [3:0] STEP_DATA    = 4'd10;
  localparam logic [3:0] STEP_SUM     = 4'd11;

  // Register reset values
  localparam logic [7:0]  RST_FRAME_TYPE     = 8'h05;
  localparam logic [7:0]  RST_COMMAND_TYPE   = 8'h01;
  localparam logic [15:0] RST_TARGET_ADDRESS = 16'h0000;
  localparam logic [7:0]  RST_ACK_REQUEST    = 8'h00;
  localparam logic [7:0]  RST_HOP_RADIUS     = 8'h07;
  localparam logic [7:0]  RST_ROUTE_MODE     = 8'h01;

  typedef enum logic [2:0] {
    REG_FRAME_TYPE     = 3'd0,
    REG_COMMAND_TYPE   = 3'd1,
    REG_TARGET_ADDRESS = 3'd2,
    REG_ACK_REQUEST    = 3'd3,
    REG_HOP_RADIUS     = 3'd4,
    REG_ROUTE_MODE     = 3'd5
  } reg_idx_t;

  typedef struct packed {
    logic [7:0]  frame_type;
    logic [7:0]  command_type;
    logic [15:0] target_address;
    logic [7:0]  ack_request;
    logic [7:0]  hop_radius;
    logic [7:0]  route_mode;
  } cfg_t;

  // One classified payload byte, as queued between front and back
  typedef struct packed {
    logic [7:0] data;
    logic [7:0] len;
    logic       first;
    logic       last;
  } item_t;

endpackage

// ===== rtl/rdrf_front.sv =====
module rdrf_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [7:0]        in_payload_byte,
  input  logic [7:0]        in_payload_length,
  input  logic              q_full,
  output logic              push,
  output rdrf_pkg::item_t   push_item
);

  logic [7:0] bytes_left_r;
  logic [7:0] bytes_left_nxt;
  logic [7:0] len_clamped;
  logic       first;

  assign in_stall = q_full;
  assign push     = in_valid && !q_full;
  assign first    = (bytes_left_r == 8'd0);

  // Clamp the length into the legal range
  always_comb begin
    if (in_payload_length == 8'd0) begin
      len_clamped = rdrf_pkg::MIN_PAYLOAD;
    end else if (in_payload_length > rdrf_pkg::MAX_PAYLOAD) begin
      len_clamped = rdrf_pkg::MAX_PAYLOAD;
    end else begin
      len_clamped = in_payload_length;
    end
  end

  always_comb begin
    push_item.data  = in_payload_byte;
    push_item.len   = len_clamped;
    push_item.first = first;
    push_item.last  = first ? (len_clamped == 8'd1) : (bytes_left_r == 8'd1);
    bytes_left_nxt  = bytes_left_r;
    if (push) begin
      bytes_left_nxt = (first ? len_clamped : bytes_left_r) - 8'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bytes_left_r <= 8'd0;
    end else begin
      bytes_left_r <= bytes_left_nxt;
    end
  end

endmodule

// ===== rtl/rdrf_queue.sv =====
module rdrf_queue #(
  parameter int DEPTH = 4
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  input  rdrf_pkg::item_t push_item,
  output logic            full,
  input  logic            pop,
  output logic            head_valid,
  output rdrf_pkg::item_t head_item
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  rdrf_pkg::item_t mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r;
  logic [PTR_W-1:0] wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r;
  logic [PTR_W-1:0] rd_ptr_nxt;
  logic [CNT_W-1:0] count_r;
  logic [CNT_W-1:0] count_nxt;

  assign full       = (count_r == CNT_W'(DEPTH));
  assign head_valid = (count_r != '0);
  assign head_item  = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + PTR_W'(1);
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + PTR_W'(1);
    end
    if (push && !pop) begin
      count_nxt = count_r + CNT_W'(1);
    end else if (pop && !push) begin
      count_nxt = count_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

endmodule

// ===== rtl/rdrf_back.sv =====
module rdrf_back (
  input  logic            clk,
  input  logic            rst_n,
  input  rdrf_pkg::cfg_t  cfg,
  input  logic            head_valid,
  input  rdrf_pkg::item_t head_item,
  output logic            pop,
  output logic            out_valid,
  input  logic            out_stall,
  output logic [7:0]      out_byte,
  output logic            out_frame_end
);

  logic [3:0] step_r;
  logic [3:0] step_nxt;
  logic [3:0] cur_step;
  logic [7:0] xor_r;
  logic [7:0] xor_nxt;
  logic [7:0] byte_sel;
  logic       advance;
  logic       emit;
  logic       done;
  logic       out_valid_r;
  logic       out_valid_nxt;
  logic [7:0] out_byte_r;
  logic       out_frame_end_r;

  assign advance  = !out_valid_r || !out_stall;
  assign emit     = head_valid && advance;
  // Non-first bytes skip the header and start at the data position
  assign cur_step = (step_r == rdrf_pkg::STEP_FTYPE && !head_item.first) ?
                    rdrf_pkg::STEP_DATA : step_r;
  assign done     = (cur_step == rdrf_pkg::STEP_SUM) ||
                    (cur_step == rdrf_pkg::STEP_DATA && !head_item.last);
  assign pop      = emit && done;

  always_comb begin
    case (cur_step)
      rdrf_pkg::STEP_FTYPE:   byte_sel = cfg.frame_type;
      rdrf_pkg::STEP_FNUM:    byte_sel = rdrf_pkg::FRAME_NUMBER;
      rdrf_pkg::STEP_CMD:     byte_sel = cfg.command_type;
      rdrf_pkg::STEP_LOADLEN: byte_sel = rdrf_pkg::LOAD_OVERHEAD + head_item.len;
      rdrf_pkg::STEP_ADDR_HI: byte_sel = cfg.target_address[15:8];
      rdrf_pkg::STEP_ADDR_LO: byte_sel = cfg.target_address[7:0];
      rdrf_pkg::STEP_ACK:     byte_sel = cfg.ack_request;
      rdrf_pkg::STEP_HOP:     byte_sel = cfg.hop_radius;
      rdrf_pkg::STEP_ROUTE:   byte_sel = cfg.route_mode;
      rdrf_pkg::STEP_PLEN:    byte_sel = head_item.len;
      rdrf_pkg::STEP_DATA:    byte_sel = head_item.data;
      default:                byte_sel = xor_r;
    endcase
  end

  always_comb begin
    step_nxt      = step_r;
    xor_nxt       = xor_r;
    out_valid_nxt = out_valid_r && out_stall;
    if (emit) begin
      out_valid_nxt = 1'b1;
      step_nxt      = done ? rdrf_pkg::STEP_FTYPE : cur_step + 4'd1;
      if (cur_step == rdrf_pkg::STEP_SUM) begin
        xor_nxt = 8'd0;
      end else if (cur_step == rdrf_pkg::STEP_FTYPE) begin
        xor_nxt = byte_sel;
      end else begin
        xor_nxt = xor_r ^ byte_sel;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_byte_r      <= byte_sel;
      out_frame_end_r <= (cur_step == rdrf_pkg::STEP_SUM);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r      <= rdrf_pkg::STEP_FTYPE;
      xor_r       <= 8'd0;
      out_valid_r <= 1'b0;
    end else begin
      step_r      <= step_nxt;
      xor_r       <= xor_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_byte      = out_byte_r;
  assign out_frame_end = out_frame_end_r;

`ifndef SYNTHESIS
  a_step_range: assert property (@(posedge clk) disable iff (!rst_n)
    step_r <= rdrf_pkg::STEP_SUM)
    else $error("sequencer step out of range");

  a_pop_needs_head: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> head_valid)
    else $error("pop from empty queue");

  a_hold_no_pop: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_stall) |-> !pop && !emit)
    else $error("queue advanced while output register held");

  a_sum_on_last: assert property (@(posedge clk) disable iff (!rst_n)
    (emit && cur_step == rdrf_pkg::STEP_SUM) |-> head_item.last)
    else $error("checksum emitted for a byte that is not last");

  a_mid_entry_head: assert property (@(posedge clk) disable iff (!rst_n)
    (step_r != rdrf_pkg::STEP_FTYPE) |-> head_valid)
    else $error("head entry vanished mid sequence");
`endif

endmodule

// ===== rtl/radio_data_request_framer.sv =====
// Channel   | Handshake                  | Payload
// ----------+----------------------------+------------------------------------
// in        | in_valid / in_stall        | in_payload_byte, in_payload_length
// out       | out_valid / out_stall      | out_byte, out_frame_end
// config    | psel penable pwrite pready | paddr, pwdata, prdata
//
// One payload byte is taken per cycle while the queue has room. A first byte
// of a frame yields 11 output bytes (12 for a one-byte frame), a middle byte 1
// and a last byte 2; the back sequencer emits one byte per cycle while the
// output is not stalled, so the output rate bounds the frame: length + 11 bytes.
// An accepted byte is queued, then its first output byte is registered.
// Reset (rst_n low, synchronous) empties the queue, clears the frame position
// counter and loads the register defaults. Output stall freezes the output
// register; the queue absorbs up to QUEUE_DEPTH bytes before in_stall rises.
module radio_data_request_framer #(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic        clk,
  input  logic        rst_n,
  // input channel
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_payload_byte,
  input  logic [7:0]  in_payload_length,
  // result channel
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  out_byte,
  output logic        out_frame_end,
  // configuration port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  rdrf_pkg::cfg_t  cfg_r;
  rdrf_pkg::cfg_t  cfg_nxt;
  rdrf_pkg::item_t push_item;
  rdrf_pkg::item_t head_item;
  logic            push;
  logic            pop;
  logic            q_full;
  logic            head_valid;
  logic            cfg_wr;
  logic [2:0]      reg_idx;

  // Register file: write on the access phase, ignore addresses past the list
  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite;
  assign reg_idx = paddr[4:2];

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_wr) begin
      case (reg_idx)
        rdrf_pkg::REG_FRAME_TYPE:     cfg_nxt.frame_type     = pwdata[7:0];
        rdrf_pkg::REG_COMMAND_TYPE:   cfg_nxt.command_type   = pwdata[7:0];
        rdrf_pkg::REG_TARGET_ADDRESS: cfg_nxt.target_address = pwdata[15:0];
        rdrf_pkg::REG_ACK_REQUEST:    cfg_nxt.ack_request    = pwdata[7:0];
        rdrf_pkg::REG_HOP_RADIUS:     cfg_nxt.hop_radius     = pwdata[7:0];
        rdrf_pkg::REG_ROUTE_MODE:     cfg_nxt.route_mode     = pwdata[7:0];
        default:                      cfg_nxt = cfg_r;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      rdrf_pkg::REG_FRAME_TYPE:     prdata = {24'd0, cfg_r.frame_type};
      rdrf_pkg::REG_COMMAND_TYPE:   prdata = {24'd0, cfg_r.command_type};
      rdrf_pkg::REG_TARGET_ADDRESS: prdata = {16'd0, cfg_r.target_address};
      rdrf_pkg::REG_ACK_REQUEST:    prdata = {24'd0, cfg_r.ack_request};
      rdrf_pkg::REG_HOP_RADIUS:     prdata = {24'd0, cfg_r.hop_radius};
      rdrf_pkg::REG_ROUTE_MODE:     prdata = {24'd0, cfg_r.route_mode};
      default:                      prdata = 32'd0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.frame_type     <= rdrf_pkg::RST_FRAME_TYPE;
      cfg_r.command_type   <= rdrf_pkg::RST_COMMAND_TYPE;
      cfg_r.target_address <= rdrf_pkg::RST_TARGET_ADDRESS;
      cfg_r.ack_request    <= rdrf_pkg::RST_ACK_REQUEST;
      cfg_r.hop_radius     <= rdrf_pkg::RST_HOP_RADIUS;
      cfg_r.route_mode     <= rdrf_pkg::RST_ROUTE_MODE;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  // Front: clamp length, track frame position, tag first and last bytes
  rdrf_front u_front (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_payload_byte   (in_payload_byte),
    .in_payload_length (in_payload_length),
    .q_full            (q_full),
    .push              (push),
    .push_item         (push_item)
  );

  // Queue: decouple the front (one byte per cycle while not full) from the header bursts
  rdrf_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_item  (push_item),
    .full       (q_full),
    .pop        (pop),
    .head_valid (head_valid),
    .head_item  (head_item)
  );

  // Back: expand each tagged byte into header, data and checksum bytes
  rdrf_back u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg           (cfg_r),
    .head_valid    (head_valid),
    .head_item     (head_item),
    .pop           (pop),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_byte      (out_byte),
    .out_frame_end (out_frame_end)
  );

endmodule
